// ===== design/pcis_pkg.sv =====
// Shared types, constants and helpers for the pulse-count image sensor sequencer.
// Depends on nothing; every module of the block imports it.
package pcis_pkg;

  // Image geometry and converter width
  localparam int ROWS        = 32;
  localparam int COLS        = 32;
  localparam int SAMPLE_BITS = 12;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int IDX_W = 10;
  localparam int SMP_W = 12;
  localparam int CNT_W = 8;
  localparam int STEP_W = 5;

  localparam logic [SMP_W-1:0] SAMPLE_MASK =
    (SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'((1 << SAMPLE_BITS) - 1);

  // Sensor register map
  localparam logic [2:0] SR_COLSEL = 3'd0;
  localparam logic [2:0] SR_ROWSEL = 3'd1;
  localparam logic [2:0] SR_VSW    = 3'd2;
  localparam logic [2:0] SR_HSW    = 3'd3;
  localparam logic [2:0] SR_VREF   = 3'd4;
  localparam logic [2:0] SR_CONFIG = 3'd5;
  localparam logic [2:0] SR_NBIAS  = 3'd6;
  localparam logic [2:0] SR_AOBIAS = 3'd7;

  localparam logic [7:0] CTRL_ON  = 8'd16;
  localparam logic [7:0] CTRL_AMP = 8'd8;

  // Last step of the configure sequence, and the jump over the reference write
  localparam logic [STEP_W-1:0] CFG_STEP_LAST     = STEP_W'(23);
  localparam logic [STEP_W-1:0] CFG_STEP_PRE_VREF = STEP_W'(15);
  localparam logic [STEP_W-1:0] CFG_STEP_CONFIG   = STEP_W'(20);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_COLUMN_BIAS   = 2'd0,
    CFG_BUFFER_BIAS   = 2'd1,
    CFG_AMP_GAIN      = 2'd2,
    CFG_AMP_REFERENCE = 2'd3
  } cfg_idx_t;

  // Input commands
  typedef enum logic [1:0] {
    CMD_CONFIGURE = 2'd0,
    CMD_WRITE     = 2'd1,
    CMD_START     = 2'd2,
    CMD_SAMPLE    = 2'd3
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PULSE  = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Sensor control lines
  typedef enum logic [2:0] {
    LINE_PRES = 3'd0,
    LINE_PINC = 3'd1,
    LINE_VRES = 3'd2,
    LINE_VINC = 3'd3,
    LINE_AMP  = 3'd4
  } line_t;

  // Work classes handed from front to back
  typedef enum logic [2:0] {
    JOB_CONFIG,
    JOB_WRITE,
    JOB_START,
    JOB_PIXEL,
    JOB_REJECT
  } job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [2:0]       addr;
    logic [7:0]       value;
    logic [IDX_W-1:0] idx;
    logic [SMP_W-1:0] sample;
    logic             row_end;
    logic             img_end;
  } job_t;

  // Register file contents seen by the back end
  typedef struct packed {
    logic [7:0] column_bias;
    logic [7:0] buffer_bias;
    logic [2:0] amp_gain;
    logic [7:0] amp_reference;
  } cfg_regs_t;

  typedef struct packed {
    line_t            line;
    logic [CNT_W-1:0] count;
  } group_t;

  // One pulse group of a register write: pointer reset, pointer inc,
  // value reset, value inc
  function automatic group_t write_group(input logic [1:0] sub,
                                         input logic [2:0] addr,
                                         input logic [7:0] value);
    group_t g;
    case (sub)
      2'd0: begin
        g.line  = LINE_PRES;
        g.count = CNT_W'(1);
      end
      2'd1: begin
        g.line  = LINE_PINC;
        g.count = CNT_W'(addr);
      end
      2'd2: begin
        g.line  = LINE_VRES;
        g.count = CNT_W'(1);
      end
      default: begin
        g.line  = LINE_VINC;
        g.count = value;
      end
    endcase
    return g;
  endfunction

endpackage

// ===== design/pcis_front.sv =====
// Front end: accepts commands, tracks the scan position and classifies
// each item into a job for the back end. Depends on pcis_pkg.
module pcis_front
  import pcis_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_command,
  input  logic [2:0]       in_reg_address,
  input  logic [7:0]       in_reg_value,
  input  logic [SMP_W-1:0] in_sample,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic             scanning_r, scanning_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0] col_count_r, col_count_nxt;
  logic             row_end, img_end;
  logic [IDX_W-1:0] idx;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Position of the current pixel
  assign row_end = (col_count_r == COL_W'(COLS - 1));
  assign img_end = row_end && (row_count_r == ROW_W'(ROWS - 1));
  assign idx     = IDX_W'(32'(row_count_r) * COLS + 32'(col_count_r));

  // Classify the item
  always_comb begin
    q_job         = '0;
    q_job.kind    = JOB_REJECT;
    q_job.addr    = in_reg_address;
    q_job.value   = in_reg_value;
    q_job.idx     = idx;
    q_job.sample  = in_sample & SAMPLE_MASK;
    q_job.row_end = row_end;
    q_job.img_end = img_end;
    case (cmd_t'(in_command))
      CMD_CONFIGURE: q_job.kind = scanning_r ? JOB_REJECT : JOB_CONFIG;
      CMD_WRITE:     q_job.kind = scanning_r ? JOB_REJECT : JOB_WRITE;
      CMD_START:     q_job.kind = JOB_START;
      CMD_SAMPLE:    q_job.kind = scanning_r ? JOB_PIXEL : JOB_REJECT;
      default:       q_job.kind = JOB_REJECT;
    endcase
  end

  // Advance the scan position on each transfer
  always_comb begin
    scanning_nxt  = scanning_r;
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    if (q_push) begin
      if (q_job.kind == JOB_START) begin
        scanning_nxt  = 1'b1;
        row_count_nxt = '0;
        col_count_nxt = '0;
      end else if (q_job.kind == JOB_PIXEL) begin
        if (img_end) begin
          scanning_nxt  = 1'b0;
          row_count_nxt = '0;
          col_count_nxt = '0;
        end else if (row_end) begin
          row_count_nxt = row_count_r + ROW_W'(1);
          col_count_nxt = '0;
        end else begin
          col_count_nxt = col_count_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r  <= 1'b0;
      row_count_r <= '0;
      col_count_r <= '0;
    end else begin
      scanning_r  <= scanning_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
    end
  end

endmodule

// ===== design/pcis_queue.sv =====
// Two-entry job queue between front and back ends.
// Depends on pcis_pkg for the job type.
module pcis_queue
  import pcis_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full       = (fill_r == 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign head_job   = entry_r[rd_ptr_r];

  // Move pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/pcis_back.sv =====
// Back end: steps through the pulse groups of the head job, one step per cycle
// unless out_ready stalls, into a registered output stage. Depends on pcis_pkg.
module pcis_back
  import pcis_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  job_t             head_job,
  input  cfg_regs_t        cfg,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [2:0]       out_line,
  output logic [CNT_W-1:0] out_count,
  output logic [IDX_W-1:0] out_pixel_index,
  output logic [SMP_W-1:0] out_pixel_value,
  output logic             out_image_done,
  output logic             out_last
);

  logic [STEP_W-1:0] step_r, step_nxt, step_adv;
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r, kind_nxt;
  line_t             line_r, line_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SMP_W-1:0]  value_r, value_nxt;
  logic              done_r, done_nxt;
  logic              last_r, last_nxt;

  logic              go, emit, fin;
  logic [2:0]        cw_addr;
  logic [7:0]        cw_value;
  logic [7:0]        ctrl_word;
  group_t            grp;

  assign go  = head_valid && (!out_valid_r || out_ready);
  assign pop = go && fin;

  assign ctrl_word = (cfg.amp_gain != 3'd0) ?
                     (CTRL_ON | CTRL_AMP | 8'(cfg.amp_gain)) : CTRL_ON;

  // Pick the register write of the configure sequence
  always_comb begin
    case (step_r[4:2])
      3'd0: begin
        cw_addr  = SR_NBIAS;
        cw_value = cfg.column_bias;
      end
      3'd1: begin
        cw_addr  = SR_AOBIAS;
        cw_value = cfg.buffer_bias;
      end
      3'd2: begin
        cw_addr  = SR_VSW;
        cw_value = 8'd0;
      end
      3'd3: begin
        cw_addr  = SR_HSW;
        cw_value = 8'd0;
      end
      3'd4: begin
        cw_addr  = SR_VREF;
        cw_value = cfg.amp_reference;
      end
      default: begin
        cw_addr  = SR_CONFIG;
        cw_value = ctrl_word;
      end
    endcase
  end

  // Decode the current step of the head job
  always_comb begin
    grp       = '0;
    emit      = 1'b0;
    fin       = 1'b0;
    last_nxt  = 1'b0;
    kind_nxt  = KIND_PULSE;
    idx_nxt   = '0;
    value_nxt = '0;
    done_nxt  = 1'b0;
    step_adv  = step_r + STEP_W'(1);
    case (head_job.kind)
      JOB_CONFIG: begin
        grp      = write_group(step_r[1:0], cw_addr, cw_value);
        emit     = (grp.count != '0);
        fin      = (step_r == CFG_STEP_LAST);
        last_nxt = fin;
        if (step_r == CFG_STEP_PRE_VREF && cfg.amp_gain == 3'd0) begin
          step_adv = CFG_STEP_CONFIG;
        end
      end
      JOB_WRITE: begin
        grp      = write_group(step_r[1:0], head_job.addr, head_job.value);
        emit     = (grp.count != '0);
        fin      = (step_r == STEP_W'(3));
        last_nxt = fin || (step_r == STEP_W'(2) && head_job.value == 8'd0);
      end
      JOB_START: begin
        grp.count = CNT_W'(1);
        case (step_r)
          STEP_W'(0): grp.line = LINE_PRES;
          STEP_W'(1): grp.line = LINE_PINC;
          STEP_W'(2): grp.line = LINE_VRES;
          STEP_W'(3): grp.line = LINE_PRES;
          STEP_W'(4): grp.line = LINE_VRES;
          default:    grp.line = LINE_AMP;
        endcase
        emit     = 1'b1;
        fin      = (step_r == STEP_W'(5));
        last_nxt = fin;
      end
      JOB_PIXEL: begin
        emit = 1'b1;
        if (step_r == STEP_W'(0)) begin
          kind_nxt  = KIND_PIXEL;
          idx_nxt   = head_job.idx;
          value_nxt = head_job.sample;
          done_nxt  = head_job.img_end;
        end else begin
          grp.count = CNT_W'(1);
          case (step_r)
            STEP_W'(1): grp.line = LINE_VINC;
            STEP_W'(2): grp.line = LINE_PRES;
            STEP_W'(3): grp.line = LINE_PINC;
            STEP_W'(4): grp.line = LINE_VINC;
            STEP_W'(5): grp.line = LINE_PRES;
            STEP_W'(6): grp.line = LINE_VRES;
            default:    grp.line = LINE_AMP;
          endcase
        end
        // Skip the row step inside a row
        if (step_r == STEP_W'(1) && !head_job.row_end) begin
          step_adv = STEP_W'(7);
        end
        fin      = (step_r == STEP_W'(7)) ||
                   (step_r == STEP_W'(4) && head_job.img_end);
        last_nxt = fin;
      end
      default: begin
        kind_nxt = KIND_REJECT;
        emit     = 1'b1;
        fin      = 1'b1;
        last_nxt = 1'b1;
      end
    endcase
    line_nxt  = (kind_nxt == KIND_PULSE) ? grp.line : LINE_PRES;
    count_nxt = (kind_nxt == KIND_PULSE) ? grp.count : '0;
  end

  // Advance the step counter, restart on each new job
  always_comb begin
    step_nxt = step_r;
    if (go) begin
      step_nxt = fin ? '0 : step_adv;
    end
    out_valid_nxt = out_valid_r;
    if (go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the output payload until its transfer
  always_ff @(posedge clk) begin
    if (go && emit) begin
      kind_r  <= kind_nxt;
      line_r  <= line_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      value_r <= value_nxt;
      done_r  <= done_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_line        = line_r;
  assign out_count       = count_r;
  assign out_pixel_index = idx_r;
  assign out_pixel_value = value_r;
  assign out_image_done  = done_r;
  assign out_last        = last_r;

endmodule

// ===== design/pulse_count_image_sensor_sequencer_core.sv =====
// Pulse-count image sensor sequencer: front end, job queue and back end.
// The input transfer is registered in the queue and the first result in the back
// end's output stage; the back end emits one step per cycle unless out_ready holds
// it back, and finishes one item before it takes the next from the queue.
// A new item is taken while the queue has room. Synchronous active-low reset
// clears the scan state, queue, output stage and the configuration registers.
module pulse_count_image_sensor_sequencer_core
  import pcis_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_command,
  input  logic [2:0]       in_reg_address,
  input  logic [7:0]       in_reg_value,
  input  logic [SMP_W-1:0] in_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [2:0]       out_line,
  output logic [CNT_W-1:0] out_count,
  output logic [IDX_W-1:0] out_pixel_index,
  output logic [SMP_W-1:0] out_pixel_value,
  output logic             out_image_done,
  output logic             out_last
);

  cfg_regs_t cfg_r, cfg_nxt;
  logic      q_full, q_push, q_pop, q_head_valid;
  job_t      q_job, q_head_job;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COLUMN_BIAS:   cfg_nxt.column_bias   = cfg_data;
        CFG_BUFFER_BIAS:   cfg_nxt.buffer_bias   = cfg_data;
        CFG_AMP_GAIN:      cfg_nxt.amp_gain      = cfg_data[2:0];
        CFG_AMP_REFERENCE: cfg_nxt.amp_reference = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pcis_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_reg_address (in_reg_address),
    .in_reg_value   (in_reg_value),
    .in_sample      (in_sample),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (q_job)
  );

  pcis_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  pcis_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_job        (q_head_job),
    .cfg             (cfg_r),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_line        (out_line),
    .out_count       (out_count),
    .out_pixel_index (out_pixel_index),
    .out_pixel_value (out_pixel_value),
    .out_image_done  (out_image_done),
    .out_last        (out_last)
  );

endmodule
